/* rtl/ftl_pkg.sv */
// ----------------------------------------------------------------------------
// ftl_pkg
// Shared types, constants and character functions for the FRU type/length
// field decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ftl_pkg;

   // Field type code from header bits 7:6
   typedef enum logic [1:0] {
      KIND_HEX   = 2'd0,
      KIND_BCD   = 2'd1,
      KIND_SIX   = 2'd2,
      KIND_EIGHT = 2'd3
   } kind_type;

   // Decode job handed from front end to back end
   typedef struct packed {
      kind_type    kind;
      logic [23:0] word;   // body byte in [7:0]; gathered 6-bit group for KIND_SIX
      logic        fend;   // job carries the last body byte of the field
   } job_type;

   // Job queue occupancy as seen by both ends
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] ASCII_OFFSET = 8'h20;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;

   // Lower-case hex digit
   function automatic logic [7:0] hex_char(input logic [3:0] v);
      logic [7:0] r;
      if (v < 4'd10) begin
         r = CHAR_ZERO + {4'd0, v};
      end else begin
         r = CHAR_LOWER_A + {4'd0, v} - 8'd10;
      end
      return r;
   endfunction

   // BCD plus character set "0123456789 -.:,_"
   function automatic logic [7:0] bcd_char(input logic [3:0] v);
      logic [7:0] r;
      unique case (v)
         4'd10:   r = 8'h20;   // space
         4'd11:   r = 8'h2d;   // dash
         4'd12:   r = 8'h2e;   // period
         4'd13:   r = 8'h3a;   // colon
         4'd14:   r = 8'h2c;   // comma
         4'd15:   r = 8'h5f;   // underscore
         default: r = CHAR_ZERO + {4'd0, v};
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/ftl_queue.sv */
// ----------------------------------------------------------------------------
// ftl_queue
// Short job queue between the byte front end and the character back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ftl_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire ftl_pkg::job_type          push_job,
   input  wire logic                      pop,
   output ftl_pkg::job_type               head_job,
   output ftl_pkg::queue_status_type      status
);

   ftl_pkg::job_type                mem_ff [ftl_pkg::QUEUE_DEPTH];
   logic [ftl_pkg::QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [ftl_pkg::QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [ftl_pkg::QUEUE_AW:0]      count_ff,  count_in;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job     = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (ftl_pkg::QUEUE_AW+1)'(ftl_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

`default_nettype wire

/* rtl/ftl_front.sv */
// ----------------------------------------------------------------------------
// ftl_front
// Accepts FRU bytes, tracks header/body state, gathers 6-bit groups and
// queues one decode job per byte (or per group) that yields characters.
// ----------------------------------------------------------------------------
`default_nettype none

module ftl_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [7:0]                req_tdata,   // [7:0] data_byte
   input  wire ftl_pkg::queue_status_type status,
   output logic                           push,
   output ftl_pkg::job_type               push_job
);

   logic                in_body_ff, in_body_in;
   ftl_pkg::kind_type   kind_ff,    kind_in;
   logic [5:0]          left_ff,    left_in;
   logic [15:0]         group_ff,   group_in;
   logic [1:0]          count_ff,   count_in;

   logic        accept;
   logic [5:0]  left_dec;
   logic        fend;
   logic [23:0] six_word;

   assign req_tready = !status.full;
   assign accept     = req_tvalid && !status.full;
   assign left_dec   = left_ff - 6'd1;
   assign fend       = (left_dec == 6'd0);

   // Merge the new byte into the pending 6-bit group, first byte lowest
   always_comb begin
      case (count_ff)
         2'd0:    six_word = {16'd0, req_tdata};
         2'd1:    six_word = {8'd0, req_tdata, group_ff[7:0]};
         default: six_word = {req_tdata, group_ff};
      endcase
   end

   // Header/body sequencing and job generation
   always_comb begin
      in_body_in = in_body_ff;
      kind_in    = kind_ff;
      left_in    = left_ff;
      group_in   = group_ff;
      count_in   = count_ff;
      push       = 1'b0;
      push_job   = '{kind: kind_ff, word: {16'd0, req_tdata}, fend: fend};
      if (accept) begin
         if (!in_body_ff) begin
            kind_in    = ftl_pkg::kind_type'(req_tdata[7:6]);
            left_in    = req_tdata[5:0];
            group_in   = '0;
            count_in   = '0;
            in_body_in = (req_tdata[5:0] != 6'd0);
         end else begin
            left_in = left_dec;
            if (kind_ff == ftl_pkg::KIND_SIX && count_ff < 2'd2 && !fend) begin
               // hold byte until the group is full
               group_in = six_word[15:0];
               count_in = count_ff + 2'd1;
            end else begin
               push = 1'b1;
               if (kind_ff == ftl_pkg::KIND_SIX) begin
                  push_job.word = six_word;
               end
               group_in = '0;
               count_in = '0;
            end
            if (fend) begin
               in_body_in = 1'b0;
               group_in   = '0;
               count_in   = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_body_ff <= 1'b0;
         kind_ff    <= ftl_pkg::KIND_HEX;
         left_ff    <= '0;
         group_ff   <= '0;
         count_ff   <= '0;
      end else begin
         in_body_ff <= in_body_in;
         kind_ff    <= kind_in;
         left_ff    <= left_in;
         group_ff   <= group_in;
         count_ff   <= count_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/ftl_back.sv */
// ----------------------------------------------------------------------------
// ftl_back
// Steps through the queued jobs and emits one decoded character per cycle
// into a registered output stage while a job waits and rsp_tready allows.
// ----------------------------------------------------------------------------
`default_nettype none

module ftl_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ftl_pkg::queue_status_type status,
   input  wire ftl_pkg::job_type          head_job,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [7:0]                     rsp_tdata,   // [7:0] out_char
   output logic [2:0]                     rsp_tuser,   // [1:0] field_kind, [2] run_last
   output logic                           rsp_tlast    // field_end
);

   logic [1:0]          idx_ff,   idx_in;
   logic                valid_ff, valid_in;
   logic [7:0]          char_ff,  char_in;
   ftl_pkg::kind_type   kind_ff;
   logic                fend_ff;
   logic                last_ff;

   logic        out_free;
   logic        emit;
   logic [1:0]  last_idx;
   logic        is_last;
   logic [5:0]  six_bits;
   logic [3:0]  nibble;

   assign out_free = !valid_ff || rsp_tready;
   assign emit     = out_free && !status.empty;

   // Characters per job, minus one
   always_comb begin
      unique case (head_job.kind)
         ftl_pkg::KIND_HEX:                     last_idx = 2'd1;
         ftl_pkg::KIND_SIX:                     last_idx = 2'd3;
         ftl_pkg::KIND_BCD, ftl_pkg::KIND_EIGHT: last_idx = 2'd0;
         default:                               last_idx = 2'd0;
      endcase
   end

   assign is_last = (idx_ff == last_idx);
   assign pop     = emit && is_last;
   assign nibble  = (idx_ff == 2'd0) ? head_job.word[7:4] : head_job.word[3:0];

   // Six-bit character slice, least significant first
   always_comb begin
      case (idx_ff)
         2'd0:    six_bits = head_job.word[5:0];
         2'd1:    six_bits = head_job.word[11:6];
         2'd2:    six_bits = head_job.word[17:12];
         default: six_bits = head_job.word[23:18];
      endcase
   end

   // Character decode
   always_comb begin
      unique case (head_job.kind)
         ftl_pkg::KIND_HEX:   char_in = ftl_pkg::hex_char(nibble);
         ftl_pkg::KIND_BCD:   char_in = ftl_pkg::bcd_char(head_job.word[3:0]);
         ftl_pkg::KIND_SIX:   char_in = {2'd0, six_bits} + ftl_pkg::ASCII_OFFSET;
         ftl_pkg::KIND_EIGHT: char_in = head_job.word[7:0];
         default:             char_in = head_job.word[7:0];
      endcase
   end

   // Character index and output valid
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (out_free) begin
         valid_in = !status.empty;
      end
      if (emit) begin
         idx_in = is_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      if (emit) begin
         char_ff <= char_in;
         kind_ff <= head_job.kind;
         fend_ff <= head_job.fend && is_last;
         last_ff <= is_last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tuser  = {last_ff, kind_ff};
   assign rsp_tlast  = fend_ff;

endmodule

`default_nettype wire

/* rtl/fru_type_length_field_decoder.sv */
// ----------------------------------------------------------------------------
// fru_type_length_field_decoder
// IPMI FRU type/length field decoder: FRU area bytes in, ASCII characters out.
// ----------------------------------------------------------------------------
// Each request is one FRU byte; a header byte opens a field and yields no
// character, body bytes decode by type (hex: 2 chars, BCD plus and 8-bit: 1,
// six-bit: 4 chars per 3-byte group). The front end takes one byte per cycle
// while its 4-entry job queue has room; the back end emits one character per
// cycle while rsp_tready is not held low, so the sustained rate is one byte per
// cycle for BCD plus and 8-bit, lower for hex and six-bit. An accepted byte
// is registered in the job queue, then its characters in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fru_type_length_field_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] out_char
   output logic [2:0]       rsp_tuser,   // [1:0] field_kind, [2] run_last
   output logic             rsp_tlast    // field_end
);

   ftl_pkg::queue_status_type q_status;
   ftl_pkg::job_type          push_job;
   ftl_pkg::job_type          head_job;
   logic                      q_push;
   logic                      q_pop;

   // Byte front end
   ftl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .status     (q_status),
      .push       (q_push),
      .push_job   (push_job)
   );

   // Job queue
   ftl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .status   (q_status)
   );

   // Character back end
   ftl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .status     (q_status),
      .head_job   (head_job),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Queue never overflows
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_status.full))
      else $error("job pushed into full queue");

   // Queue never underflows
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_status.empty))
      else $error("job popped from empty queue");

   // A field end is always the last character of its job
   a_fend_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser[2])
      else $error("field end without run last");

   // A queued job reaches the output in the next cycle when the output is free
   a_job_to_output: assert property (@(posedge clock) disable iff (reset)
      (!q_status.empty && (!rsp_tvalid || rsp_tready)) |=> rsp_tvalid)
      else $error("pending job did not reach output");

endmodule

`default_nettype wire
